// File: rtl/eti_pkg.sv
package eti_pkg;

	localparam int IDX_W = 4;
	localparam int TABLE_DEPTH = 2 ** IDX_W;
	localparam int FRAC_BITS = 16;
	localparam int VAL_W = 32;
	localparam int SPC_W = 31;
	localparam int QUO_BITS = IDX_W;
	localparam int DIV_STAGES = 1 + QUO_BITS + FRAC_BITS;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int CFG_W = VAL_W;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_EVAL  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		RANGE_IN   = 2'd0,
		RANGE_LOW  = 2'd1,
		RANGE_HIGH = 2'd2
	} range_t;

	typedef enum logic [1:0] {
		CFG_AXIS_LOW     = 2'd0,
		CFG_AXIS_SPACING = 2'd1,
		CFG_LAST_INDEX   = 2'd2,
		CFG_INTERP_MODE  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [VAL_W-1:0] axis_low;
		logic [SPC_W-1:0] axis_spacing;
		logic [IDX_W-1:0] last_index;
		logic             interp_mode;
	} cfg_t;

	typedef struct packed {
		action_t          kind;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] data;
	} qitem_t;

endpackage

// File: rtl/eti_ifs.sv
interface eti_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [3:0]  entry_index;
	logic [31:0] entry_value;
	logic [31:0] sample_in;
	modport source (output valid, action, entry_index, entry_value, sample_in, input ready);
	modport sink (input valid, action, entry_index, entry_value, sample_in, output ready);
endinterface

interface eti_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] y_out;
	logic [1:0]  range_flag;
	modport source (output valid, y_out, range_flag, input ready);
	modport sink (input valid, y_out, range_flag, output ready);
endinterface

// File: rtl/eti_front.sv
module eti_front (
	input  logic            clk,
	input  logic            arst_n,
	eti_in_if.sink          in_ch,
	output logic            push,
	output eti_pkg::qitem_t push_item,
	input  logic            full
);
	import eti_pkg::*;

	logic   f_v_q;
	qitem_t f_item_q;
	qitem_t cls;

	assign in_ch.ready = !f_v_q || !full;
	assign push = f_v_q && !full;
	assign push_item = f_item_q;

	always_comb begin
		cls.kind = action_t'(in_ch.action);
		cls.idx = in_ch.entry_index;
		cls.data = (cls.kind == ACT_WRITE) ? in_ch.entry_value : in_ch.sample_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_v_q <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			f_v_q <= 1'b1;
		end else if (push) begin
			f_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			f_item_q <= cls;
		end
	end
endmodule

// File: rtl/eti_queue.sv
module eti_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  eti_pkg::qitem_t push_item,
	input  logic            pop,
	output eti_pkg::qitem_t head,
	output logic            empty,
	output logic            full
);
	import eti_pkg::*;

	qitem_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end
endmodule

// File: rtl/eti_back.sv
module eti_back (
	input  logic            clk,
	input  logic            arst_n,
	input  eti_pkg::cfg_t   cfg,
	input  logic            q_empty,
	input  eti_pkg::qitem_t q_head,
	output logic            q_pop,
	output logic            o_valid,
	input  logic            o_ready,
	output logic [31:0]     o_y,
	output logic [1:0]      o_flag
);
	import eti_pkg::*;

	localparam int DW = VAL_W + QUO_BITS + 1;
	localparam int BW = $clog2(QUO_BITS);

	typedef struct packed {
		logic                 valid;
		action_t              kind;
		logic [IDX_W-1:0]     widx;
		logic [VAL_W-1:0]     wval;
		logic                 le;
		logic                 hi;
		logic [QUO_BITS-1:0]  q;
		logic [VAL_W:0]       rem;
		logic [FRAC_BITS-1:0] frac;
	} dstg_t;

	function automatic dstg_t qstep(dstg_t s, logic [BW-1:0] b, logic [SPC_W-1:0] sp,
			logic chk);
		logic [DW-1:0] sh;
		logic [DW-1:0] r;
		dstg_t o;
		sh = DW'(sp) << b;
		r = DW'(s.rem);
		o = s;
		if (chk && r >= (DW'(sp) << QUO_BITS)) begin
			o.hi = 1'b1;
		end
		if (r >= sh) begin
			o.rem = (VAL_W+1)'(r - sh);
			o.q[b] = 1'b1;
		end
		return o;
	endfunction

	function automatic dstg_t fstep(dstg_t s, logic [SPC_W-1:0] sp);
		logic [VAL_W+1:0] r2;
		logic [VAL_W+1:0] spx;
		dstg_t o;
		r2 = {s.rem, 1'b0};
		spx = (VAL_W+2)'(sp);
		o = s;
		o.frac = {s.frac[FRAC_BITS-2:0], 1'b0};
		if (r2 >= spx) begin
			o.rem = (VAL_W+1)'(r2 - spx);
			o.frac[0] = 1'b1;
		end else begin
			o.rem = r2[VAL_W:0];
		end
		return o;
	endfunction

	logic           en;
	dstg_t          dv_s [DIV_STAGES];
	dstg_t          dv_d [DIV_STAGES];
	logic [VAL_W:0] diff;
	dstg_t          t;
	logic           hi_f;
	range_t         flag;
	logic [IDX_W-1:0] a0;
	logic [IDX_W-1:0] a1;
	logic [FRAC_BITS-1:0] fr;

	logic [VAL_W-1:0] mem [TABLE_DEPTH];

	logic                 v_s1, v_s2, v_s3, v_s4;
	range_t               flag_s1, flag_s2, flag_s3;
	logic [FRAC_BITS-1:0] frac_s1, frac_s2;
	logic [VAL_W-1:0]     lo_s1, up_s1;
	logic [VAL_W-1:0]     lower_s2, mag_s2, lower_s3, sh_s3;
	logic                 neg_s2, neg_s3;
	logic [VAL_W+FRAC_BITS-1:0] prod;
	logic [VAL_W-1:0]     y_s4;
	logic [1:0]           flag_s4;

	assign en = !v_s4 || o_ready;
	assign q_pop = en && !q_empty;

	always_comb begin
		diff = {q_head.data[VAL_W-1], q_head.data} - {cfg.axis_low[VAL_W-1], cfg.axis_low};
		dv_d[0].valid = !q_empty;
		dv_d[0].kind = q_head.kind;
		dv_d[0].widx = q_head.idx;
		dv_d[0].wval = q_head.data;
		dv_d[0].le = diff[VAL_W] || (diff == '0);
		dv_d[0].hi = (cfg.axis_spacing == '0);
		dv_d[0].q = '0;
		dv_d[0].rem = diff;
		dv_d[0].frac = '0;
		for (int k = 0; k < QUO_BITS; k++) begin
			dv_d[k+1] = qstep(dv_s[k], BW'(QUO_BITS-1-k), cfg.axis_spacing, k == 0);
		end
		for (int j = 0; j < FRAC_BITS; j++) begin
			dv_d[1+QUO_BITS+j] = fstep(dv_s[QUO_BITS+j], cfg.axis_spacing);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++) begin
				dv_s[i].valid <= 1'b0;
			end
		end else if (en) begin
			for (int i = 0; i < DIV_STAGES; i++) begin
				dv_s[i] <= dv_d[i];
			end
		end
	end

	always_comb begin
		t = dv_s[DIV_STAGES-1];
		hi_f = t.hi || (t.q >= cfg.last_index);
		if (t.le) begin
			flag = RANGE_LOW;
			a0 = '0;
		end else if (hi_f) begin
			flag = RANGE_HIGH;
			a0 = cfg.last_index;
		end else begin
			flag = RANGE_IN;
			a0 = t.q;
		end
		a1 = t.q + 1'b1;
		fr = (flag == RANGE_IN && cfg.interp_mode) ? t.frac : '0;
		prod = mag_s2 * frac_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (t.valid && t.kind == ACT_WRITE) begin
				mem[t.widx] <= t.wval;
			end
			lo_s1 <= mem[a0];
			up_s1 <= mem[a1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= t.valid && t.kind == ACT_EVAL;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flag_s1 <= flag;
			frac_s1 <= fr;
			lower_s2 <= lo_s1;
			neg_s2 <= $signed(up_s1) < $signed(lo_s1);
			mag_s2 <= ($signed(up_s1) < $signed(lo_s1)) ? lo_s1 - up_s1 : up_s1 - lo_s1;
			frac_s2 <= frac_s1;
			flag_s2 <= flag_s1;
			sh_s3 <= prod[FRAC_BITS +: VAL_W];
			lower_s3 <= lower_s2;
			neg_s3 <= neg_s2;
			flag_s3 <= flag_s2;
			y_s4 <= neg_s3 ? lower_s3 - sh_s3 : lower_s3 + sh_s3;
			flag_s4 <= flag_s3;
		end
	end

	assign o_valid = v_s4;
	assign o_y = y_s4;
	assign o_flag = flag_s4;
endmodule

// File: rtl/even_table_interpolator.sv
// Evenly spaced lookup table with optional linear interpolation in signed Q16.16.
// Write items load one of 16 entries; evaluate items return one result, writes
// return none. One item is accepted per cycle while the queue is not full; an
// evaluation passes through one input register, a four-entry queue, a pipelined
// restoring divider of one quotient or fraction bit per stage (4 + 16 stages plus
// the subtract), a registered table read, and three stages of delta, multiply and
// add. Items stay in order, so a table write is seen by every later evaluation.
// Configuration must be written only while no item is in flight.
module even_table_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	eti_in_if.sink      in_ch,
	eti_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_data
);
	import eti_pkg::*;

	cfg_t   cfg_q;
	logic   push, full, empty, pop;
	qitem_t push_item, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis_low <= '0;
			cfg_q.axis_spacing <= SPC_W'(65536);
			cfg_q.last_index <= '1;
			cfg_q.interp_mode <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_AXIS_LOW:     cfg_q.axis_low <= cfg_data;
				CFG_AXIS_SPACING: cfg_q.axis_spacing <= cfg_data[SPC_W-1:0];
				CFG_LAST_INDEX:   cfg_q.last_index <= cfg_data[IDX_W-1:0];
				CFG_INTERP_MODE:  cfg_q.interp_mode <= cfg_data[0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	eti_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.push(push), .push_item(push_item), .full(full)
	);

	eti_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item),
		.pop(pop), .head(head), .empty(empty), .full(full)
	);

	eti_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_empty(empty), .q_head(head),
		.q_pop(pop), .o_valid(out_ch.valid), .o_ready(out_ch.ready),
		.o_y(out_ch.y_out), .o_flag(out_ch.range_flag)
	);
endmodule

// File: test/even_table_interpolator_tb.sv
module even_table_interpolator_tb;
	import eti_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 400000;
	localparam int DRAIN = 40;

	typedef struct {
		logic [31:0] y;
		range_t      flag;
	} lookup_t;

	typedef struct {
		action_t     act;
		logic [3:0]  idx;
		logic [31:0] val;
		logic [31:0] smp;
		bit          typed;
		logic [31:0] y;
		range_t      flag;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = '0;
	logic [31:0] cfg_data = '0;

	eti_in_if in_ch();
	eti_out_if out_ch();

	even_table_interpolator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	logic signed [31:0] m_low = 32'sd0;
	logic [30:0] m_spc = 31'd65536;
	logic [3:0] m_last = 4'd15;
	logic m_interp = 1'b1;
	logic [31:0] m_tab [TABLE_DEPTH];

	lookup_t pending_q [$];
	int errors = 0;
	int n_items = 0;
	int n_evals = 0;
	int n_checked = 0;
	int n_clamp_lo = 0;
	int n_clamp_hi = 0;
	int s_idle = 0;
	int r_idle = 0;
	bit hold_req = 1'b0;
	int cyc = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.action = 1'b0;
		in_ch.entry_index = '0;
		in_ch.entry_value = '0;
		in_ch.sample_in = '0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("%0t timeout, %0d results outstanding", $realtime, pending_q.size());
			$display("FAIL");
			$finish;
		end
	end

	function automatic lookup_t interpolate(logic [31:0] smp);
		lookup_t r;
		longint s, lo, diff, q, rem, frac, lower, upper, delta, mag;
		s = longint'($signed(smp));
		lo = longint'(m_low);
		if (s <= lo) begin
			r.y = m_tab[0];
			r.flag = RANGE_LOW;
			return r;
		end
		diff = s - lo;
		q = (m_spc == '0) ? longint'(TABLE_DEPTH) : diff / longint'(m_spc);
		if (q >= longint'(m_last)) begin
			r.y = m_tab[m_last];
			r.flag = RANGE_HIGH;
			return r;
		end
		rem = diff - q * longint'(m_spc);
		frac = (rem << FRAC_BITS) / longint'(m_spc);
		lower = longint'($signed(m_tab[q]));
		upper = longint'($signed(m_tab[q + 1]));
		r.y = lower[31:0];
		if (m_interp && frac != 0) begin
			delta = upper - lower;
			if (delta < 0) begin
				mag = ((-delta) * frac) >>> FRAC_BITS;
				r.y = 32'(lower - mag);
			end else begin
				mag = (delta * frac) >>> FRAC_BITS;
				r.y = 32'(lower + mag);
			end
		end
		r.flag = RANGE_IN;
		return r;
	endfunction

	always @(posedge clk) begin
		if (hold_req) begin
			out_ch.ready <= 1'b0;
			repeat (90) @(posedge clk);
			hold_req = 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= r_idle);
		end
	end

	always @(posedge clk) begin
		lookup_t e;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t unexpected result y=%h flag=%0d", $realtime,
					out_ch.y_out, out_ch.range_flag);
				errors++;
			end else begin
				e = pending_q.pop_front();
				n_checked++;
				if (out_ch.y_out !== e.y) begin
					$display("%0t y_out expected %h actual %h", $realtime, e.y, out_ch.y_out);
					errors++;
				end
				if (out_ch.range_flag !== e.flag) begin
					$display("%0t range_flag expected %0d actual %0d", $realtime,
						e.flag, out_ch.range_flag);
					errors++;
				end
			end
		end
	end

	task automatic send(action_t act, logic [3:0] idx, logic [31:0] val, logic [31:0] smp,
			bit typed = 1'b0, logic [31:0] ty = '0, range_t tf = RANGE_IN);
		lookup_t e;
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.entry_index <= idx;
		in_ch.entry_value <= val;
		in_ch.sample_in <= smp;
		do @(posedge clk); while (!in_ch.ready);
		n_items++;
		if (act == ACT_WRITE) begin
			m_tab[idx] = val;
		end else begin
			e = interpolate(smp);
			if (typed) begin
				e.y = ty;
				e.flag = tf;
			end
			n_evals++;
			if (e.flag == RANGE_LOW) n_clamp_lo++;
			if (e.flag == RANGE_HIGH) n_clamp_hi++;
			pending_q.push_back(e);
		end
		while ($urandom_range(0, 99) < s_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_idx_t idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_AXIS_LOW: m_low = data;
			CFG_AXIS_SPACING: m_spc = data[30:0];
			CFG_LAST_INDEX: m_last = data[3:0];
			CFG_INTERP_MODE: m_interp = data[0];
		endcase
	endtask

	function automatic logic [31:0] pick_sample();
		longint lo, span, off, s;
		int r;
		lo = longint'(m_low);
		span = (longint'(m_last) + 1) * longint'(m_spc);
		r = $urandom_range(0, 9);
		if (r < 2) return $urandom;
		if (r < 3) off = longint'($urandom_range(0, 4)) - 2;
		else if (r < 5) off = longint'($urandom_range(0, m_last + 1)) * longint'(m_spc);
		else off = {$urandom, $urandom} % span;
		s = lo + off;
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return s[31:0];
	endfunction

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			if (n_items < 170) begin
				s_idle = 31;
				r_idle = 76;
			end else if (n_items < 340) begin
				s_idle = 76;
				r_idle = 31;
			end else begin
				s_idle = 0;
				r_idle = 0;
			end
			if ($urandom_range(0, 5) == 0)
				send(ACT_WRITE, 4'($urandom), $urandom, $urandom);
			else
				send(ACT_EVAL, 4'($urandom), $urandom, pick_sample());
		end
	endtask

	row_t rows [$];

	initial begin
		logic [31:0] ev;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			ev = (i == 0) ? 32'h8000_0000 : (i == 15) ? 32'h7fff_ffff : 32'(i) << 16;
			if (i == 7) ev = 32'hfff0_0000;
			rows.push_back('{ACT_WRITE, 4'(i), ev, 32'h0, 1'b0, '0, RANGE_IN});
		end
		rows.push_back('{ACT_EVAL, 4'hf, 32'hffff_ffff, 32'h8000_0000, 1'b1,
			32'h8000_0000, RANGE_LOW});
		rows.push_back('{ACT_EVAL, 4'h0, 32'h0, 32'h0, 1'b1, 32'h8000_0000, RANGE_LOW});
		rows.push_back('{ACT_EVAL, 4'h0, 32'h0, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff, RANGE_HIGH});
		rows.push_back('{ACT_EVAL, 4'h0, 32'h0, 32'h000f_0000, 1'b1, 32'h7fff_ffff, RANGE_HIGH});
		rows.push_back('{ACT_EVAL, 4'h0, 32'h0, 32'h0001_0000, 1'b1, 32'h0001_0000, RANGE_IN});
		rows.push_back('{ACT_EVAL, 4'h0, 32'h0, 32'h0001_8000, 1'b0, '0, RANGE_IN});
		rows.push_back('{ACT_EVAL, 4'h0, 32'h0, 32'h0000_0001, 1'b0, '0, RANGE_IN});
		rows.push_back('{ACT_EVAL, 4'h0, 32'h0, 32'h0006_c000, 1'b0, '0, RANGE_IN});
		rows.push_back('{ACT_EVAL, 4'h0, 32'h0, 32'h000e_ffff, 1'b0, '0, RANGE_IN});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send(rows[i].act, rows[i].idx, rows[i].val, rows[i].smp,
				rows[i].typed, rows[i].y, rows[i].flag);
		settle();

		cfg_write(CFG_INTERP_MODE, 32'd0);
		cfg_write(CFG_LAST_INDEX, 32'd1);
		cfg_write(CFG_AXIS_SPACING, 32'd1);
		cfg_write(CFG_AXIS_LOW, 32'h8000_0000);
		random_phase(60);
		settle();

		cfg_write(CFG_INTERP_MODE, 32'd1);
		cfg_write(CFG_LAST_INDEX, 32'd15);
		cfg_write(CFG_AXIS_SPACING, 32'h7fff_ffff);
		cfg_write(CFG_AXIS_LOW, 32'h8000_0000);
		hold_req = 1'b1;
		random_phase(80);
		settle();

		cfg_write(CFG_AXIS_LOW, 32'h7fff_ffff);
		cfg_write(CFG_AXIS_SPACING, 32'd3);
		random_phase(30);
		settle();

		cfg_write(CFG_AXIS_LOW, 32'hffc0_0000);
		cfg_write(CFG_AXIS_SPACING, 32'h0001_0000);
		cfg_write(CFG_LAST_INDEX, 32'd15);
		random_phase(110);
		settle();

		for (int p = 0; p < 3; p++) begin
			cfg_write(CFG_AXIS_LOW, $urandom);
			cfg_write(CFG_AXIS_SPACING, $urandom_range(1, 32'h00ff_ffff));
			cfg_write(CFG_LAST_INDEX, $urandom_range(1, 15));
			cfg_write(CFG_INTERP_MODE, $urandom_range(0, 1));
			hold_req = (p == 1);
			random_phase(60);
			settle();
		end

		$display("covered %0d items, %0d evaluations checked (%0d clamped low, %0d high)",
			n_items, n_checked, n_clamp_lo, n_clamp_hi);
		$display("settings spanned axis extremes, spacing 1 to max, both interpolation modes");
		if (errors == 0 && pending_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/eti_pkg.sv
rtl/eti_ifs.sv
rtl/eti_front.sv
rtl/eti_queue.sv
rtl/eti_back.sv
rtl/even_table_interpolator.sv
test/even_table_interpolator_tb.sv
